// ===== design/equirect_pixel_to_cube_face_defines.svh =====
// assertion macros shared by the equirect to cube face design
// no dependencies; included by the modules that carry assertions
`ifndef EQUIRECT_PIXEL_TO_CUBE_FACE_DEFINES_SVH
`define EQUIRECT_PIXEL_TO_CUBE_FACE_DEFINES_SVH

`ifndef ASSERT_OFF
`define E2C_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define E2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define E2C_ASSERT(lbl, clk, rst_n, prop, msg)
`define E2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/e2c_pkg.sv =====
// types and constants of the equirect to cube face design
// no dependencies; imported by every module but e2c_div_pipe
package e2c_pkg;

    localparam int REG_W    = 13;
    localparam int IDX_W    = 2;
    localparam int ANG_W    = 16;
    localparam int TRIG_W   = 16;
    localparam int MAG_W    = 15;
    localparam int FACE_W   = 3;
    localparam int SINE_LAT = 4;
    localparam int SPAN_W   = 13;

    localparam logic [IDX_W-1:0] REG_OUT_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_OUT_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FACE_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_FACE_HEIGHT = 2'd3;

    localparam logic [REG_W-1:0] RST_OUT_WIDTH   = 13'd4096;
    localparam logic [REG_W-1:0] RST_OUT_HEIGHT  = 13'd2048;
    localparam logic [REG_W-1:0] RST_FACE_WIDTH  = 13'd1024;
    localparam logic [REG_W-1:0] RST_FACE_HEIGHT = 13'd1024;

    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd0;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [ANG_W-1:0] HALF_TURN    = 16'd32768;
    localparam logic [MAG_W-1:0] Q14_ONE      = 15'd16384;

    localparam logic [MAG_W-1:0] SIN_A = 15'd25736;
    localparam logic [MAG_W-1:0] SIN_B = 15'd10512;
    localparam logic [MAG_W-1:0] SIN_C = 15'd1160;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [FACE_W-1:0]        face;
        logic signed [TRIG_W-1:0] nc;
        logic signed [TRIG_W-1:0] nr;
        logic [MAG_W-1:0]         mag;
    } item_t;

    function automatic logic [MAG_W-1:0] trig_mag(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W-1:0] n;
        n = -v;
        trig_mag = v[TRIG_W-1] ? MAG_W'(n) : MAG_W'(v);
    endfunction

endpackage

// ===== design/e2c_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
// no dependencies; used by e2c_front and e2c_back
module e2c_div_pipe #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13,
    parameter int QUO_W = 29
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);
    localparam int CMP_W = NUM_W + DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] rem_ext;
        logic [CMP_W-1:0] den_sh;
        logic             take;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign rem_ext = CMP_W'(rem_in);
        assign den_sh  = CMP_W'(den_in) << (QUO_W - 1 - s);
        assign take    = rem_ext >= den_sh;

        always_ff @(posedge clk)
        begin
            quo_reg[s] <= {quo_in[QUO_W-2:0], take};
        end

        if (s < QUO_W - 1)
        begin : g_keep
            logic [NUM_W-1:0] rem_next;
            logic [CMP_W-1:0] diff;
            assign diff     = rem_ext - den_sh;
            assign rem_next = take ? NUM_W'(diff) : rem_in;
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// ===== design/e2c_sine.sv =====
// four-stage q2.14 sine from a 16-bit fraction-of-turn angle
// depends on e2c_pkg
module e2c_sine (
    input  logic                              clk,
    input  logic [e2c_pkg::ANG_W-1:0]         ang,
    output logic signed [e2c_pkg::TRIG_W-1:0] sin_q14
);
    import e2c_pkg::*;

    logic [MAG_W-1:0]   x_in;
    logic [2*MAG_W-1:0] sq;
    logic [MAG_W-1:0]   s1_x_reg, s1_x2_reg, s1_x2_next;
    logic               s1_neg_reg;
    logic [2*MAG_W-1:0] pc;
    logic [MAG_W-1:0]   s2_x_reg, s2_x2_reg, s2_t_reg, s2_t_next;
    logic               s2_neg_reg;
    logic [2*MAG_W-1:0] pt;
    logic [MAG_W-1:0]   s3_x_reg, s3_t_reg, s3_t_next;
    logic               s3_neg_reg;
    logic [2*MAG_W-1:0] pm;
    logic [TRIG_W-1:0]  m_ext;
    logic signed [TRIG_W-1:0] out_next, out_reg;

    // odd quadrants run the quarter wave backwards
    assign x_in = ang[ANG_W-2] ? Q14_ONE - MAG_W'(ang[ANG_W-3:0]) : MAG_W'(ang[ANG_W-3:0]);
    assign sq         = x_in * x_in;
    assign s1_x2_next = sq[28:14];

    assign pc        = s1_x2_reg * SIN_C;
    assign s2_t_next = SIN_B - pc[28:14];

    assign pt        = s2_x2_reg * s2_t_reg;
    assign s3_t_next = SIN_A - pt[28:14];

    assign pm       = s3_x_reg * s3_t_reg;
    assign m_ext    = TRIG_W'(pm[28:14]);
    assign out_next = s3_neg_reg ? -m_ext : m_ext;

    always_ff @(posedge clk)
    begin
        s1_x_reg   <= x_in;
        s1_x2_reg  <= s1_x2_next;
        s1_neg_reg <= ang[ANG_W-1];
        s2_x_reg   <= s1_x_reg;
        s2_x2_reg  <= s1_x2_reg;
        s2_t_reg   <= s2_t_next;
        s2_neg_reg <= s1_neg_reg;
        s3_x_reg   <= s2_x_reg;
        s3_t_reg   <= s3_t_next;
        s3_neg_reg <= s2_neg_reg;
        out_reg    <= out_next;
    end

    assign sin_q14 = out_reg;

endmodule

// ===== design/e2c_front.sv =====
// front end: angles, direction vector and face pick for each pixel
// depends on e2c_pkg, e2c_div_pipe and e2c_sine
module e2c_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [COORD_BITS-1:0]      pix_x,
    input  logic [COORD_BITS-1:0]      pix_y,
    input  logic [e2c_pkg::REG_W-1:0]  out_width,
    input  logic [e2c_pkg::REG_W-1:0]  out_height,
    output logic                       push,
    output e2c_pkg::item_t             item
);
    import e2c_pkg::*;

    localparam int DIV_W = COORD_BITS + 17;
    localparam int LAT   = DIV_W + SINE_LAT + 2;

    logic [REG_W-1:0] wd, hd;
    logic [DIV_W-1:0] num_th, num_ph, quo_th, quo_ph;
    logic [ANG_W-1:0] theta, phi;
    logic signed [TRIG_W-1:0] sin_th, cos_th, sin_ph, cos_ph;
    logic [LAT-1:0] vld_reg;

    logic [2*MAG_W-1:0] px_prod, py_prod;
    logic signed [TRIG_W-1:0] x_next, y_next, x_reg, y_reg, z_reg;

    logic [MAG_W-1:0] ax, ay, az, a_max;
    item_t item_next, item_reg;

    assign wd = (out_width > REG_W'(1)) ? out_width - REG_W'(1) : REG_W'(1);
    assign hd = (out_height > REG_W'(1)) ? out_height - REG_W'(1) : REG_W'(1);
    assign num_th = (DIV_W'(pix_x) << ANG_W) + DIV_W'(wd >> 1);
    assign num_ph = (DIV_W'(pix_y) << (ANG_W - 1)) + DIV_W'(hd >> 1);

    e2c_div_pipe #(.NUM_W(DIV_W), .DEN_W(REG_W), .QUO_W(DIV_W)) u_div_th (
        .clk (clk),
        .num (num_th),
        .den (wd),
        .quo (quo_th)
    );

    e2c_div_pipe #(.NUM_W(DIV_W), .DEN_W(REG_W), .QUO_W(DIV_W)) u_div_ph (
        .clk (clk),
        .num (num_ph),
        .den (hd),
        .quo (quo_ph)
    );

    assign theta = quo_th[ANG_W-1:0];
    assign phi   = HALF_TURN - quo_ph[ANG_W-1:0];

    e2c_sine u_sin_th (.clk(clk), .ang(theta), .sin_q14(sin_th));
    e2c_sine u_cos_th (.clk(clk), .ang(theta + QUARTER_TURN), .sin_q14(cos_th));
    e2c_sine u_sin_ph (.clk(clk), .ang(phi), .sin_q14(sin_ph));
    e2c_sine u_cos_ph (.clk(clk), .ang(phi + QUARTER_TURN), .sin_q14(cos_ph));

    // direction components, products truncated toward zero
    assign px_prod = trig_mag(cos_th) * trig_mag(sin_ph);
    assign py_prod = trig_mag(sin_th) * trig_mag(sin_ph);
    assign x_next  = (cos_th[TRIG_W-1] ^ sin_ph[TRIG_W-1]) ?
                     -TRIG_W'(px_prod[28:14]) : TRIG_W'(px_prod[28:14]);
    assign y_next  = (sin_th[TRIG_W-1] ^ sin_ph[TRIG_W-1]) ?
                     -TRIG_W'(py_prod[28:14]) : TRIG_W'(py_prod[28:14]);

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= cos_ph;
    end

    // dominant axis with the fixed tie order
    always_comb
    begin
        ax    = trig_mag(x_reg);
        ay    = trig_mag(y_reg);
        az    = trig_mag(z_reg);
        a_max = ax;
        if (ay > a_max)
        begin
            a_max = ay;
        end
        if (az > a_max)
        begin
            a_max = az;
        end
        item_next.mag = a_max;
        if (y_reg[TRIG_W-1] && ay == a_max)
        begin
            item_next.face = FACE_LEFT;
            item_next.nc   = x_reg;
            item_next.nr   = z_reg;
        end
        else if (!x_reg[TRIG_W-1] && x_reg != '0 && ax == a_max)
        begin
            item_next.face = FACE_FRONT;
            item_next.nc   = y_reg;
            item_next.nr   = z_reg;
        end
        else if (!y_reg[TRIG_W-1] && y_reg != '0 && ay == a_max)
        begin
            item_next.face = FACE_RIGHT;
            item_next.nc   = -x_reg;
            item_next.nr   = z_reg;
        end
        else if (x_reg[TRIG_W-1] && ax == a_max)
        begin
            item_next.face = FACE_BACK;
            item_next.nc   = -y_reg;
            item_next.nr   = z_reg;
        end
        else if (!z_reg[TRIG_W-1] && z_reg != '0 && az == a_max)
        begin
            item_next.face = FACE_BOTTOM;
            item_next.nc   = -x_reg;
            item_next.nr   = -y_reg;
        end
        else
        begin
            item_next.face = FACE_TOP;
            item_next.nc   = -x_reg;
            item_next.nr   = y_reg;
        end
        // null direction lands on the face center
        if (a_max == '0)
        begin
            item_next.mag = MAG_W'(1);
            item_next.nc  = '0;
            item_next.nr  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], take};
        end
    end

    assign push = vld_reg[LAT-1];
    assign item = item_reg;

endmodule

// ===== design/e2c_queue.sv =====
// short queue between the front and back ends, registered read
// depends on e2c_pkg and the assertion macro header
`include "equirect_pixel_to_cube_face_defines.svh"

module e2c_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  e2c_pkg::item_t wr_item,
    output logic           full,
    output logic           rd_valid,
    output e2c_pkg::item_t rd_item
);
    import e2c_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;
    logic              rd_valid_reg;
    item_t             rd_item_reg;

    assign pop         = cnt_reg != '0;
    assign wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
        rd_item_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= pop;
        end
    end

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = rd_valid_reg;
    assign rd_item  = rd_item_reg;

    `E2C_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "queue push while full")
    `E2C_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
    `E2C_ASSERT_NEXT(a_pop_valid, clk, rst_n, pop, rd_valid, "queue pop without read transfer")

endmodule

// ===== design/e2c_back.sv =====
// back end: clamp, scale and divide to face coordinates
// depends on e2c_pkg and e2c_div_pipe
module e2c_back #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  e2c_pkg::item_t                     in_item,
    input  logic [e2c_pkg::REG_W-1:0]          face_width,
    input  logic [e2c_pkg::REG_W-1:0]          face_height,
    output logic                               done,
    output logic [e2c_pkg::FACE_W-1:0]         face_index,
    output logic [COORD_BITS+FRAC_BITS-1:0]    face_col,
    output logic [COORD_BITS+FRAC_BITS-1:0]    face_row
);
    import e2c_pkg::*;

    localparam int OUT_W  = COORD_BITS + FRAC_BITS;
    localparam int NUMV_W = MAG_W + 1;
    localparam int PROD_W = NUMV_W + SPAN_W;
    localparam int DVD_W  = PROD_W + FRAC_BITS + 1;
    localparam int QUO_W  = SPAN_W + FRAC_BITS;
    localparam int XW     = QUO_W + OUT_W;
    localparam logic [XW-1:0] LIM_X = (XW'(1) << OUT_W) - XW'(1);

    logic [SPAN_W-1:0] span_c, span_r;
    logic [NUMV_W-1:0] two_a;
    logic [NUMV_W-1:0] num_c_next, num_r_next, num_c_reg, num_r_reg;
    logic [MAG_W-1:0]  b0_a_reg, b1_a_reg;
    logic [FACE_W-1:0] b0_face_reg, b1_face_reg;
    logic              b0_vld_reg, b1_vld_reg;
    logic [PROD_W-1:0] prod_c_next, prod_r_next, prod_c_reg, prod_r_reg;
    logic [DVD_W-1:0]  dvd_c, dvd_r;
    logic [NUMV_W-1:0] dvs;
    logic [QUO_W-1:0]  quo_c, quo_r;
    logic [QUO_W-1:0]  dl_vld_reg;
    logic [FACE_W-1:0] dl_face_reg [QUO_W];
    logic [XW-1:0]     qx_c, qx_r;
    logic [OUT_W-1:0]  col_next, row_next, col_reg, row_reg;
    logic [FACE_W-1:0] face_reg;
    logic              done_reg;

    function automatic logic [NUMV_W-1:0] clamp_num(
        input logic signed [TRIG_W-1:0] n,
        input logic [MAG_W-1:0]         a
    );
        logic signed [NUMV_W+1:0] s;
        logic [NUMV_W-1:0]        lim;
        s   = (NUMV_W+2)'(n) + $signed((NUMV_W+2)'(a));
        lim = {a, 1'b0};
        if (s[NUMV_W+1])
        begin
            clamp_num = '0;
        end
        else if (s[NUMV_W:0] > {1'b0, lim})
        begin
            clamp_num = lim;
        end
        else
        begin
            clamp_num = s[NUMV_W-1:0];
        end
    endfunction

    assign span_c = (face_width == '0) ? '0 : face_width - REG_W'(1);
    assign span_r = (face_height == '0) ? '0 : face_height - REG_W'(1);

    assign num_c_next = clamp_num(in_item.nc, in_item.mag);
    assign num_r_next = clamp_num(in_item.nr, in_item.mag);

    assign prod_c_next = num_c_reg * span_c;
    assign prod_r_next = num_r_reg * span_r;

    assign dvd_c = (DVD_W'(prod_c_reg) << FRAC_BITS) + DVD_W'(b1_a_reg);
    assign dvd_r = (DVD_W'(prod_r_reg) << FRAC_BITS) + DVD_W'(b1_a_reg);
    assign dvs   = {b1_a_reg, 1'b0};
    assign two_a = {b0_a_reg, 1'b0};

    e2c_div_pipe #(.NUM_W(DVD_W), .DEN_W(NUMV_W), .QUO_W(QUO_W)) u_div_col (
        .clk (clk),
        .num (dvd_c),
        .den (dvs),
        .quo (quo_c)
    );

    e2c_div_pipe #(.NUM_W(DVD_W), .DEN_W(NUMV_W), .QUO_W(QUO_W)) u_div_row (
        .clk (clk),
        .num (dvd_r),
        .den (dvs),
        .quo (quo_r)
    );

    assign qx_c     = XW'(quo_c);
    assign qx_r     = XW'(quo_r);
    assign col_next = (qx_c > LIM_X) ? OUT_W'(LIM_X) : OUT_W'(qx_c);
    assign row_next = (qx_r > LIM_X) ? OUT_W'(LIM_X) : OUT_W'(qx_r);

    always_ff @(posedge clk)
    begin
        num_c_reg   <= num_c_next;
        num_r_reg   <= num_r_next;
        b0_a_reg    <= in_item.mag;
        b0_face_reg <= in_item.face;
        // product never exceeds 2a times the span
        prod_c_reg  <= (num_c_reg > two_a) ? '0 : prod_c_next;
        prod_r_reg  <= (num_r_reg > two_a) ? '0 : prod_r_next;
        b1_a_reg    <= b0_a_reg;
        b1_face_reg <= b0_face_reg;
        col_reg     <= col_next;
        row_reg     <= row_next;
        face_reg    <= dl_face_reg[QUO_W-1];
    end

    always_ff @(posedge clk)
    begin
        dl_face_reg[0] <= b1_face_reg;
        for (int i = 1; i < QUO_W; i++)
        begin
            dl_face_reg[i] <= dl_face_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg <= 1'b0;
            b1_vld_reg <= 1'b0;
            dl_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            b0_vld_reg <= in_valid;
            b1_vld_reg <= b0_vld_reg;
            dl_vld_reg <= {dl_vld_reg[QUO_W-2:0], b1_vld_reg};
            done_reg   <= dl_vld_reg[QUO_W-1];
        end
    end

    assign done       = done_reg;
    assign face_index = face_reg;
    assign face_col   = col_reg;
    assign face_row   = row_reg;

endmodule

// ===== design/equirect_pixel_to_cube_face.sv =====
// equirect pixel to cube face lookup: a pixel taken by start passes the front end's
// divider and sine pipelines, the queue and the back end's divider pipelines before
// the done strobe; throughput one pixel per cycle, busy stays low
// reset clears all pipeline valids and loads the size registers with defaults
// depends on e2c_pkg, e2c_front, e2c_queue and e2c_back
module equirect_pixel_to_cube_face #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             pix_x,
    input  logic [COORD_BITS-1:0]             pix_y,
    input  logic                              wr_en,
    input  logic [e2c_pkg::IDX_W-1:0]         wr_index,
    input  logic [e2c_pkg::REG_W-1:0]         wr_data,
    output logic                              done,
    output logic [e2c_pkg::FACE_W-1:0]        face_index,
    output logic [COORD_BITS+FRAC_BITS-1:0]   face_col,
    output logic [COORD_BITS+FRAC_BITS-1:0]   face_row
);
    import e2c_pkg::*;

    logic [REG_W-1:0] out_width_reg, out_height_reg, face_width_reg, face_height_reg;
    logic             take, push, full, q_valid;
    item_t            f_item, q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg   <= RST_OUT_WIDTH;
            out_height_reg  <= RST_OUT_HEIGHT;
            face_width_reg  <= RST_FACE_WIDTH;
            face_height_reg <= RST_FACE_HEIGHT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_OUT_WIDTH:   out_width_reg   <= wr_data;
                REG_OUT_HEIGHT:  out_height_reg  <= wr_data;
                REG_FACE_WIDTH:  face_width_reg  <= wr_data;
                REG_FACE_HEIGHT: face_height_reg <= wr_data;
                default:         out_width_reg   <= out_width_reg;
            endcase
        end
    end

    assign take = start && !busy;
    assign busy = full;

    e2c_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .out_width  (out_width_reg),
        .out_height (out_height_reg),
        .push       (push),
        .item       (f_item)
    );

    e2c_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (f_item),
        .full     (full),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    e2c_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_item     (q_item),
        .face_width  (face_width_reg),
        .face_height (face_height_reg),
        .done        (done),
        .face_index  (face_index),
        .face_col    (face_col),
        .face_row    (face_row)
    );

endmodule
